FILE: sv/tcrp_pkg.sv
// ----------------------------------------------------------------------------
// tcrp_pkg
// Types, constants and arithmetic helpers shared by the tiled 2x2 conv pyramid.
// ----------------------------------------------------------------------------
package tcrp_pkg;

  localparam int PIX_W   = 16;  // Q8.8 pixel
  localparam int WGT_W   = 16;  // Q4.12 weight
  localparam int POS_W   = 8;   // raster row or column
  localparam int SIZE_W  = 9;   // image size register
  localparam int ACC_W   = 34;  // sum of four Q12.20 products
  localparam int LVL_W   = 3;   // level count
  localparam int IDX_W   = 3;   // configuration register index
  localparam int CFG_W   = 16;  // configuration write data
  localparam int LEVEL_LIMIT = 16;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_SIZE   = 3'd0,
    REG_WEIGHT_TL    = 3'd1,
    REG_WEIGHT_TR    = 3'd2,
    REG_WEIGHT_BL    = 3'd3,
    REG_WEIGHT_BR    = 3'd4
  } cfg_reg_t;

  // Kernel shared by every level.
  typedef struct packed {
    logic signed [WGT_W-1:0] top_left;
    logic signed [WGT_W-1:0] top_right;
    logic signed [WGT_W-1:0] bottom_left;
    logic signed [WGT_W-1:0] bottom_right;
  } weights_t;

  // Word handed from cell to cell. A word that was absorbed into a partial
  // sum keeps moving with live cleared, so the end of the row always sees it.
  typedef struct packed {
    logic                    valid;
    logic                    live;
    logic signed [PIX_W-1:0] v;
    logic [POS_W-1:0]        r;
    logic [POS_W-1:0]        c;
  } token_t;

  // Round a Q12.20 sum to Q8.8, then ReLU and saturate.
  function automatic logic signed [PIX_W-1:0] round_relu_sat(
      input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]    biased;
    logic signed [ACC_W-12:0] shifted;
    biased  = {acc[ACC_W-1], acc} + (ACC_W+1)'(2048);
    shifted = biased[ACC_W:12];
    if (shifted < 0) begin
      return '0;
    end else if (shifted > (ACC_W-11)'(32767)) begin
      return PIX_W'(32767);
    end else begin
      return shifted[PIX_W-1:0];
    end
  endfunction

endpackage

FILE: sv/tcrp_pix_if.sv
// ----------------------------------------------------------------------------
// tcrp_pix_if
// Pixel channel: one Q8.8 pixel per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcrp_pix_if;
  import tcrp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

FILE: sv/tcrp_tile_if.sv
// ----------------------------------------------------------------------------
// tcrp_tile_if
// Tile result channel: one reduced tile per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcrp_tile_if;
  import tcrp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] tile_result;
  logic [3:0]              tile_row;
  logic [3:0]              tile_col;
  logic [4:0]              grid_size;
  logic                    image_done;

  modport source (output valid, output tile_result, output tile_row,
                  output tile_col, output grid_size, output image_done,
                  input ready);
  modport sink   (input valid, input tile_result, input tile_row,
                  input tile_col, input grid_size, input image_done,
                  output ready);
endinterface

FILE: sv/tcrp_cell.sv
// ----------------------------------------------------------------------------
// tcrp_cell
// One pyramid level: 2x2 stride-2 convolution with ReLU on a streamed plane.
// ----------------------------------------------------------------------------
module tcrp_cell #(
  parameter int LVL            = 0,
  parameter int MAX_IMAGE_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tcrp_pkg::weights_t weights,
  input  tcrp_pkg::token_t  tok_in,
  output tcrp_pkg::token_t  tok_out
);
  import tcrp_pkg::*;

  localparam int DEPTH  = MAX_IMAGE_SIZE >> (LVL + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Top-row partial sums, one per window of this level.
  logic signed [ACC_W-1:0] partials [0:(1 << ADDR_W)-1];

  token_t                  tok_a;
  token_t                  tok_next;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] rd;
  logic [ADDR_W-1:0]       addr_a;
  logic signed [ACC_W-1:0] hold;
  logic signed [WGT_W-1:0] w_sel;
  logic signed [31:0]      p;
  logic signed [ACC_W-1:0] sum;
  logic                    act;

  // Pick the tap weight from the position parity.
  always_comb begin
    case ({tok_in.r[0], tok_in.c[0]})
      2'b00:   w_sel = weights.top_left;
      2'b01:   w_sel = weights.top_right;
      2'b10:   w_sel = weights.bottom_left;
      default: w_sel = weights.bottom_right;
    endcase
    p = tok_in.v * w_sel;
  end

  // First stage: multiply and read the partial sum of this window.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a <= '0;
    end else begin
      tok_a <= tok_in;
    end
    prod   <= {{(ACC_W-32){p[31]}}, p};
    addr_a <= tok_in.c[ADDR_W:1];
    rd     <= partials[tok_in.c[ADDR_W:1]];
  end

  // Second stage: add the product to what the window has so far.
  always_comb begin
    act = tok_a.valid && tok_a.live && en;
    if (tok_a.r[0] && !tok_a.c[0]) begin
      sum = rd + prod;
    end else if (tok_a.c[0]) begin
      sum = hold + prod;
    end else begin
      sum = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (act && !tok_a.c[0]) begin
      hold <= sum;
    end
    if (act && !tok_a.r[0] && tok_a.c[0]) begin
      partials[addr_a] <= sum;
    end
  end

  // A finished window moves up one level, other words retire.
  always_comb begin
    tok_next = tok_a;
    if (act) begin
      if (tok_a.r[0] && tok_a.c[0]) begin
        tok_next.v = round_relu_sat(sum);
        tok_next.r = tok_a.r >> 1;
        tok_next.c = tok_a.c >> 1;
      end else begin
        tok_next.live = 1'b0;
      end
    end
  end

  // Hand the word on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: sv/tiled_conv2x2_relu_pyramid.sv
// ----------------------------------------------------------------------------
// tiled_conv2x2_relu_pyramid
// Streams a square image and reduces each tile by a 2x2 conv/ReLU pyramid.
// ----------------------------------------------------------------------------
// Usage: pixels of a square image arrive on pixel_in in raster order, one
// word per pixel. The image is cut into tiles of side 2^levels, where the
// level count halves image_size until it is 16 or less. Each tile leaves as
// one word on tile_out once its last pixel has been taken; pixels outside
// the tile grid give no word. With zero levels every pixel passes unchanged.
// One pixel is in work at a time. It walks a row of MAX_LEVELS level cells,
// and a tile word passes a pending register before the output register.
// pixel_in takes the next word once the pixel has retired at the end of
// the row or its tile word has entered the output register.
// The output register lets the next pixel in while a tile word waits; a pixel
// that finishes a tile while the previous word is still held waits at the
// end of the row until tile_out takes it.
// Reset sets image_size to 32, all weights to 1.0 and the raster position to
// the image start. Writing image_size also restarts the raster position.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module tiled_conv2x2_relu_pyramid #(
  parameter int MAX_IMAGE_SIZE = 256,
  parameter int MAX_TILE_SIDE  = 16,
  parameter int MAX_LEVELS     = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  tcrp_pix_if.sink               pixel_in,
  tcrp_tile_if.source            tile_out,
  input  logic                   cfg_we,
  input  logic [tcrp_pkg::IDX_W-1:0] cfg_index,
  input  logic [tcrp_pkg::CFG_W-1:0] cfg_data
);
  import tcrp_pkg::*;

  logic [SIZE_W-1:0] image_size;
  weights_t          weights;
  logic [POS_W-1:0]  pixel_row;
  logic [POS_W-1:0]  pixel_col;
  logic [LVL_W-1:0]  level_count;
  logic              busy;
  logic [SIZE_W-1:0] grid;

  logic [SIZE_W-1:0] n_eff;
  logic [LVL_W-1:0]  lc_use;
  logic [SIZE_W-1:0] grid_next;
  logic [SIZE_W:0]   span;
  logic              accept;

  token_t            tok [0:MAX_LEVELS];
  token_t            pend;

  // Level count for an image side, capped by the level and tile limits.
  function automatic logic [LVL_W-1:0] levels_for(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    logic [LVL_W-1:0]  d;
    m = n;
    d = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (m > SIZE_W'(LEVEL_LIMIT)) begin
        m = m >> 1;
        d = d + 1'b1;
      end
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (d > 0 && (32'd1 << d) > MAX_TILE_SIDE) begin
        d = d - 1'b1;
      end
    end
    return d;
  endfunction

  // Effective image side and the tile grid for the current pixel.
  always_comb begin
    if (image_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (image_size > SIZE_W'(MAX_IMAGE_SIZE)) begin
      n_eff = SIZE_W'(MAX_IMAGE_SIZE);
    end else begin
      n_eff = image_size;
    end
    lc_use    = (pixel_row == '0 && pixel_col == '0) ? levels_for(n_eff) : level_count;
    grid_next = n_eff >> lc_use;
    span      = {1'b0, grid_next} << lc_use;
  end

  assign pixel_in.ready = !busy;
  assign accept         = pixel_in.valid && !busy;

  // Configuration registers and the raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size          <= SIZE_W'(32);
      weights.top_left     <= WGT_W'(4096);
      weights.top_right    <= WGT_W'(4096);
      weights.bottom_left  <= WGT_W'(4096);
      weights.bottom_right <= WGT_W'(4096);
      pixel_row           <= '0;
      pixel_col           <= '0;
      level_count         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_SIZE: begin
          image_size <= cfg_data[SIZE_W-1:0];
          pixel_row  <= '0;
          pixel_col  <= '0;
        end
        REG_WEIGHT_TL: weights.top_left     <= cfg_data;
        REG_WEIGHT_TR: weights.top_right    <= cfg_data;
        REG_WEIGHT_BL: weights.bottom_left  <= cfg_data;
        REG_WEIGHT_BR: weights.bottom_right <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      level_count <= lc_use;
      if ({1'b0, pixel_col} + 1'b1 >= n_eff) begin
        pixel_col <= '0;
        pixel_row <= ({1'b0, pixel_row} + 1'b1 >= n_eff) ? '0 : pixel_row + 1'b1;
      end else begin
        pixel_col <= pixel_col + 1'b1;
      end
    end
  end

  // Launch the accepted pixel into the row of level cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else begin
      tok[0].valid <= accept;
      tok[0].live  <= ({1'b0, pixel_row} < span) && ({1'b0, pixel_col} < span);
      tok[0].v     <= pixel_in.pixel_value;
      tok[0].r     <= pixel_row;
      tok[0].c     <= pixel_col;
    end
    if (accept) begin
      grid <= grid_next;
    end
  end

  // Row of level cells; cells above the level count pass words unchanged.
  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_level
    tcrp_cell #(
      .LVL            (g),
      .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (LVL_W'(g) < level_count),
      .weights (weights),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // Finished word waits here, then moves to the output register.
  always_ff @(posedge clk) begin
    if (tok[MAX_LEVELS].valid) begin
      pend.live <= tok[MAX_LEVELS].live;
      pend.v    <= tok[MAX_LEVELS].v;
      pend.r    <= tok[MAX_LEVELS].r;
      pend.c    <= tok[MAX_LEVELS].c;
    end
    if (rst) begin
      busy           <= 1'b0;
      pend.valid     <= 1'b0;
      tile_out.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (tok[MAX_LEVELS].valid) begin
        if (tok[MAX_LEVELS].live) begin
          pend.valid <= 1'b1;
        end else begin
          busy <= 1'b0;
        end
      end
      if (pend.valid && (!tile_out.valid || tile_out.ready)) begin
        pend.valid     <= 1'b0;
        busy           <= 1'b0;
        tile_out.valid <= 1'b1;
      end else if (tile_out.valid && tile_out.ready) begin
        tile_out.valid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pend.valid && (!tile_out.valid || tile_out.ready)) begin
      tile_out.tile_result <= pend.v;
      tile_out.tile_row    <= pend.r[3:0];
      tile_out.tile_col    <= pend.c[3:0];
      tile_out.grid_size   <= grid[4:0];
      tile_out.image_done  <= ({1'b0, pend.r} + 1'b1 == grid) &&
                              ({1'b0, pend.c} + 1'b1 == grid) && pend.live;
    end
  end

endmodule
